@@ hdl/profile_peak_centroider_defines.svh @@
// Assertion macros shared by the checker
`ifndef PROFILE_PEAK_CENTROIDER_DEFINES_SVH
`define PROFILE_PEAK_CENTROIDER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define PPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/ppc_pkg.sv @@
`default_nettype none
package ppc_pkg;
    localparam int MAX_HALF_WIDTH = 2;
    localparam int HIST_DEPTH     = 5;
    localparam int NUM_W          = 67;
    localparam int DEN_W          = 35;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_HW   = 2'd1;
    localparam logic [1:0] REG_MINH = 2'd2;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] intensity;
        logic        scan_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] peak_mass;
        logic [31:0] peak_intensity;
    } t_out_item;

    // job handed from front to back
    typedef struct packed {
        logic             pass;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [31:0]      mass;
        logic [31:0]      intensity;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_div_state;
endpackage
`default_nettype wire

@@ hdl/profile_peak_centroider.sv @@
`default_nettype none
// Profile peak centroider. Samples enter through a push/full queue port, peaks leave
// through an empty/pop port. The front handles an ordinary accepted sample at once; a
// profile apex keeps it busy through one centroid tap at a time (1, 3 or 5 taps for half
// width 0, 1 or 2) while it accumulates sum(I*m) and sum(I). The back loads a job while
// idle, runs a restoring divider at one bit per cycle over every numerator bit and then
// holds the peak until it is popped, and takes no new job before that pop; closely
// spaced apexes stall the input once the two-entry job queue fills. Centroided-mode
// beats skip the divider and go from load straight to the held peak. Configure
// only while idle; registers at 4*i over APB.
module profile_peak_centroider #(
    parameter int MaxHalfWidth = ppc_pkg::MAX_HALF_WIDTH,
    parameter int QueueDepth   = ppc_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ppc_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output ppc_pkg::t_out_item      o_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic        r_mode;
    logic [1:0]  r_hw;
    logic [31:0] r_minh;
    logic        fj_v, fj_r, bj_v, bj_r;
    ppc_pkg::t_job fj, bj;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_hw <= 2'd1; r_minh <= '0;
        end else if (psel && penable && pwrite) begin
            priority case (paddr[3:2])
                ppc_pkg::REG_MODE: r_mode <= pwdata[0];
                ppc_pkg::REG_HW:   r_hw   <= pwdata[1:0];
                ppc_pkg::REG_MINH: r_minh <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority case (paddr[3:2])
            ppc_pkg::REG_MODE: prdata = {31'd0, r_mode};
            ppc_pkg::REG_HW:   prdata = {30'd0, r_hw};
            ppc_pkg::REG_MINH: prdata = r_minh;
            default:           prdata = '0;
        endcase
    end

    ppc_front #(.MaxHalfWidth(MaxHalfWidth)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .i_mode(r_mode), .i_half_width(r_hw), .i_min_height(r_minh),
        .o_job_valid(fj_v), .o_job(fj), .i_job_ready(fj_r)
    );

    ppc_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_valid(fj_v), .o_ready(fj_r), .i_job(fj),
        .o_valid(bj_v), .i_ready(bj_r), .o_job(bj)
    );

    ppc_back u_back (
        .i_clk, .i_rst_n, .i_valid(bj_v), .o_ready(bj_r), .i_job(bj),
        .o_empty(empty), .i_pop(pop), .o_item
    );
endmodule
`default_nettype wire

@@ hdl/ppc_front.sv @@
`default_nettype none
// Front: keep history, test for apex, accumulate centroid sums one tap a cycle
module ppc_front #(
    parameter int MaxHalfWidth = ppc_pkg::MAX_HALF_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire ppc_pkg::t_in_item i_item,
    input  wire logic              i_mode,
    input  wire logic [1:0]        i_half_width,
    input  wire logic [31:0]       i_min_height,
    output logic                   o_job_valid,
    output ppc_pkg::t_job          o_job,
    input  wire logic              i_job_ready
);
    localparam int D = ppc_pkg::HIST_DEPTH;

    logic [31:0] r_mass [D];
    logic [31:0] r_inten [D];
    logic [2:0]  r_fill;
    logic        r_busy;
    logic [2:0]  r_tap;
    logic [2:0]  r_tap_end;
    logic        r_clear;
    logic        r_out_v;
    ppc_pkg::t_job r_job;

    logic        accept;
    logic [2:0]  n_fill;
    logic [31:0] w_mass [D];
    logic [31:0] w_inten [D];
    logic [32:0] w_i0mh, w_i1mh;
    logic        apex;
    logic        take_apex;
    logic [1:0]  hw;
    logic [63:0] prod;

    assign o_full      = r_busy || (r_out_v && !i_job_ready);
    assign accept      = i_push && !o_full;
    assign o_job_valid = r_out_v;
    assign o_job       = r_job;

    // shifted history as seen by this sample
    always_comb begin
        for (int k = 0; k < D - 1; k++) begin
            w_mass[k]  = r_mass[k+1];
            w_inten[k] = r_inten[k+1];
        end
        w_mass[D-1]  = i_item.mass;
        w_inten[D-1] = i_item.intensity;
        n_fill = (r_fill < 3'(D)) ? r_fill + 3'd1 : r_fill;
        w_i0mh = {1'b0, w_inten[0]} + {1'b0, i_min_height};
        w_i1mh = {1'b0, w_inten[1]} + {1'b0, i_min_height};
        apex = (w_inten[2] > i_min_height) && ({1'b0, w_inten[2]} > w_i1mh) &&
               (w_inten[2] >= w_inten[3]) && ({1'b0, w_inten[1]} > w_i0mh) &&
               (w_inten[3] >= w_inten[4]) && (n_fill == 3'(D));
        take_apex = !i_mode && apex;
        hw = (i_half_width > 2'(MaxHalfWidth)) ? 2'(MaxHalfWidth) : i_half_width;
        prod = r_inten[r_tap] * r_mass[r_tap];
    end

    // advance history, run the tap loop, hand off job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
            r_clear <= 1'b0;
            for (int k = 0; k < D; k++) begin
                r_mass[k]  <= '0;
                r_inten[k] <= '0;
            end
        end else begin
            // raise the job flag on a pass beat at or above the minimum height or a finished sum, drop it once taken
            if (accept) begin
                r_out_v <= i_mode && (i_item.intensity >= i_min_height);
            end else if (r_busy && r_tap == r_tap_end) begin
                r_out_v <= 1'b1;
            end else if (i_job_ready) begin
                r_out_v <= 1'b0;
            end
            if (accept) begin
                // keep the window for the tap loop even if scan ends
                for (int k = 0; k < D; k++) begin
                    r_mass[k]  <= (i_item.scan_end && !take_apex) ? '0 : w_mass[k];
                    r_inten[k] <= (i_item.scan_end && !take_apex) ? '0 : w_inten[k];
                end
                r_fill <= i_item.scan_end ? '0 : n_fill;
                r_job.mass      <= i_mode ? i_item.mass : '0;
                r_job.intensity <= i_mode ? i_item.intensity : w_inten[2];
                r_job.pass      <= i_mode;
                r_job.num       <= '0;
                r_job.den       <= '0;
                if (take_apex) begin
                    r_busy    <= 1'b1;
                    r_clear   <= i_item.scan_end;
                    r_tap     <= 3'd2 - 3'(hw);
                    r_tap_end <= 3'd2 + 3'(hw);
                end
            end else if (r_busy) begin
                r_job.num <= r_job.num + ppc_pkg::NUM_W'(prod);
                r_job.den <= r_job.den + ppc_pkg::DEN_W'(r_inten[r_tap]);
                if (r_tap == r_tap_end) begin
                    r_busy <= 1'b0;
                    if (r_clear) begin
                        for (int k = 0; k < D; k++) begin
                            r_mass[k]  <= '0;
                            r_inten[k] <= '0;
                        end
                    end
                end else begin
                    r_tap <= r_tap + 3'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/ppc_queue.sv @@
`default_nettype none
// Short job queue between front and back
module ppc_queue #(
    parameter int Depth = ppc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ppc_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ppc_pkg::t_job      o_job
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    ppc_pkg::t_job r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) begin
                r_mem[r_wp] <= i_job;
                r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

@@ hdl/ppc_back.sv @@
`default_nettype none
// Back: restoring divider, one quotient bit per cycle, and output register
module ppc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ppc_pkg::t_job  i_job,
    output logic                o_empty,
    input  wire logic           i_pop,
    output ppc_pkg::t_out_item  o_item
);
    localparam int NW = ppc_pkg::NUM_W;
    localparam int DW = ppc_pkg::DEN_W;

    ppc_pkg::t_div_state r_st, n_st;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [6:0]    r_cnt;
    logic [31:0]   r_quo;
    logic [31:0]   r_inten;
    ppc_pkg::t_out_item r_out;
    logic [DW:0]   w_sh;
    logic          w_ge;

    assign o_item  = r_out;
    assign o_empty = r_st != ppc_pkg::ST_DONE;
    assign o_ready = r_st == ppc_pkg::ST_IDLE;
    assign w_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ppc_pkg::ST_IDLE: if (i_valid) n_st = i_job.pass ? ppc_pkg::ST_DONE
                                                               : ppc_pkg::ST_DIV;
            ppc_pkg::ST_DIV:  if (r_cnt == 7'(NW-1)) n_st = ppc_pkg::ST_DONE;
            ppc_pkg::ST_DONE: if (i_pop) n_st = ppc_pkg::ST_IDLE;
            default:          n_st = ppc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ppc_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    // load, shift-subtract, publish
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ppc_pkg::ST_IDLE: begin
                r_num   <= i_job.num;
                r_den   <= i_job.den;
                r_rem   <= '0;
                r_cnt   <= '0;
                r_inten <= i_job.intensity;
                r_out   <= '{peak_mass: i_job.mass, peak_intensity: i_job.intensity};
            end
            ppc_pkg::ST_DIV: begin
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_quo <= {r_quo[30:0], w_ge};
                r_num <= {r_num[NW-2:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(NW-1))
                    r_out <= '{peak_mass: {r_quo[30:0], w_ge}, peak_intensity: r_inten};
            end
            ppc_pkg::ST_DONE: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/ppc_checker.sv @@
`default_nettype none
`include "profile_peak_centroider_defines.svh"
// Port-level checks
module ppc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               pready,
    input wire ppc_pkg::t_out_item o_item
);
    `PPC_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `PPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_item))
    `PPC_ASSERT_NEXT(a_pop_gap, i_clk, i_rst_n, !empty && pop, empty)
endmodule

bind profile_peak_centroider ppc_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .pready, .o_item
);
`default_nettype wire
